@@ rtl/core/skl_pkg.sv @@
package skl_pkg;

  // fixed field widths
  localparam int KEY_W        = 32;
  localparam int OP_W         = 3;
  localparam int RANK_W       = 6;
  localparam int STATUS_W     = 2;
  localparam int CAPACITY_DEF = 64;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [RANK_W-1:0]       rank_t;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 3'd0,
    OP_QUERY    = 3'd1,
    OP_CONTAINS = 3'd2,
    OP_RANK     = 3'd3,
    OP_REMOVE   = 3'd4
  } op_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_CMP  = 2'd1,
    S_UPD  = 2'd2
  } state_t;

  // control broadcast to every cell
  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic rem_en;
  } cell_ctrl_t;

endpackage

@@ rtl/core/skl_cell.sv @@
module skl_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  logic                clk,
  input  skl_pkg::cell_ctrl_t ctrl,
  input  skl_pkg::key_t       k,
  input  skl_pkg::rank_t      rank,
  input  logic [CNT_W-1:0]    count,
  input  skl_pkg::key_t       left_key,
  input  logic                left_ge,
  input  skl_pkg::key_t       right_key,
  output skl_pkg::key_t       key_q,
  output logic                ge_q,
  output logic                eq_q,
  output logic                hit_q
);
  import skl_pkg::*;

  key_t key_r;
  logic ge_r;
  logic eq_r;
  logic hit_r;
  logic occ;

  // cell holds a live key when its index is below the fill count
  assign occ = (CNT_W'(IDX) < count);

  // compare beat: empty cells act as larger than any key
  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      ge_r  <= !occ || (key_r >= k);
      eq_r  <= occ && (key_r == k);
      hit_r <= occ && (32'(rank) == 32'(IDX));
    end
  end

  // shift right on insert, shift left on remove, from the boundary up
  always_ff @(posedge clk) begin
    if (ctrl.ins_en && ge_r) begin
      key_r <= left_ge ? left_key : k;
    end else if (ctrl.rem_en && ge_r) begin
      key_r <= right_key;
    end
  end

  assign key_q = key_r;
  assign ge_q  = ge_r;
  assign eq_q  = eq_r;
  assign hit_q = hit_r;

endmodule

@@ rtl/core/skl_reduce.sv @@
module skl_reduce #(
  parameter int CAPACITY = skl_pkg::CAPACITY_DEF,
  parameter int POS_W    = 7
) (
  input  logic [CAPACITY-1:0] ge_vec,
  input  logic [CAPACITY-1:0] eq_vec,
  input  logic [CAPACITY-1:0] hit_vec,
  input  skl_pkg::key_t       keys [CAPACITY],
  output logic [POS_W-1:0]    position,
  output logic                any_eq,
  output logic                any_hit,
  output skl_pkg::key_t       rank_key
);
  import skl_pkg::*;

  logic [CAPACITY-1:0] first;
  logic [POS_W-1:0]    pos_acc;
  key_t                key_acc;

  // boundary of the thermometer of greater-or-equal flags
  assign first = ge_vec & ~(ge_vec << 1);

  // one-hot to index, and masked or over the ranked key
  always_comb begin
    pos_acc = '0;
    key_acc = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first[i]) begin
        pos_acc = pos_acc | POS_W'(i);
      end
      if (hit_vec[i]) begin
        key_acc = key_acc | keys[i];
      end
    end
  end

  assign position = (ge_vec == '0) ? POS_W'(CAPACITY) : pos_acc;
  assign any_eq   = |eq_vec;
  assign any_hit  = |hit_vec;
  assign rank_key = key_acc;

endmodule

@@ rtl/core/sorted_key_list.sv @@
// Sorted multiset of signed keys held in a row of CAPACITY cells, one key per cell,
// kept in ascending order. Each accepted item passes through S_CMP, then S_UPD: in
// S_CMP, every cell compares its key with the broadcast key (and its index with the
// rank) and registers the flags; in S_UPD, the flags are reduced to the result
// and the cells at and above the lower-bound boundary shift one place right (insert)
// or left (remove). A new item is accepted in S_UPD whenever the result register is
// free or being drained, so items follow one another without a pass through S_IDLE;
// only out_tready holding a result back stalls the flow. No clearing pass is
// needed after reset: the fill count alone says which cells hold keys.
module sorted_key_list #(
  parameter int CAPACITY = skl_pkg::CAPACITY_DEF,
  parameter int POS_W    = $clog2(CAPACITY + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [39:0]         in_tdata,   // key [31:0], rank [37:32]
  input  logic [2:0]          in_tuser,   // op [2:0]
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [((POS_W + 33 + 7) / 8) * 8 - 1:0] out_tdata, // position, found, key_out
  output logic [1:0]          out_tuser   // status [1:0]
);
  import skl_pkg::*;

  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int OUT_TDATA_W = ((POS_W + 33 + 7) / 8) * 8;

  state_t             state_r, state_nxt;
  logic [OP_W-1:0]    op_r;
  key_t               k_r;
  rank_t              rank_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               out_valid_r;
  logic [POS_W-1:0]   out_pos_r;
  logic               out_found_r;
  key_t               out_key_r;
  status_t            out_status_r;

  cell_ctrl_t          ctrl;
  logic                in_acc;
  logic                done;
  logic [CAPACITY-1:0] ge_vec, eq_vec, hit_vec;
  key_t                keys [CAPACITY];
  logic [POS_W-1:0]    red_pos;
  logic                any_eq, any_hit;
  key_t                rank_key;

  logic [POS_W-1:0]    res_pos;
  logic                res_found;
  key_t                res_key;
  status_t             res_status;
  logic                want_ins, want_rem;

  assign in_acc = in_tvalid && in_tready;
  assign done   = !out_valid_r || out_tready;

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    key_t left_key, right_key;
    logic left_ge;
    if (i == 0) begin : g_head
      assign left_key = k_r;
      assign left_ge  = 1'b0;
    end else begin : g_body
      assign left_key = keys[i-1];
      assign left_ge  = ge_vec[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_key = keys[i];
    end else begin : g_mid
      assign right_key = keys[i+1];
    end
    skl_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .k         (k_r),
      .rank      (rank_r),
      .count     (count_r),
      .left_key  (left_key),
      .left_ge   (left_ge),
      .right_key (right_key),
      .key_q     (keys[i]),
      .ge_q      (ge_vec[i]),
      .eq_q      (eq_vec[i]),
      .hit_q     (hit_vec[i])
    );
  end

  skl_reduce #(
    .CAPACITY (CAPACITY),
    .POS_W    (POS_W)
  ) u_reduce (
    .ge_vec   (ge_vec),
    .eq_vec   (eq_vec),
    .hit_vec  (hit_vec),
    .keys     (keys),
    .position (red_pos),
    .any_eq   (any_eq),
    .any_hit  (any_hit),
    .rank_key (rank_key)
  );

  // result decode from the reduced flags
  always_comb begin
    res_pos    = '0;
    res_found  = 1'b0;
    res_key    = '0;
    res_status = ST_OK;
    want_ins   = 1'b0;
    want_rem   = 1'b0;
    case (op_t'(op_r))
      OP_INSERT: begin
        res_pos = red_pos;
        if (count_r == CNT_W'(CAPACITY)) begin
          res_status = ST_FULL;
        end else begin
          want_ins = 1'b1;
        end
      end
      OP_QUERY: begin
        res_pos = red_pos;
      end
      OP_CONTAINS: begin
        res_found = any_eq;
      end
      OP_RANK: begin
        if (any_hit) begin
          res_key = rank_key;
        end else begin
          res_key    = '1;
          res_status = ST_RANGE;
        end
      end
      OP_REMOVE: begin
        res_found = any_eq;
        want_rem  = any_eq;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (done) begin
          state_nxt = in_acc ? S_CMP : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // fsm outputs
  always_comb begin
    in_tready   = 1'b0;
    ctrl        = '0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
      end
      S_CMP: begin
        ctrl.cmp_en = 1'b1;
      end
      S_UPD: begin
        in_tready   = done;
        ctrl.ins_en = done && want_ins;
        ctrl.rem_en = done && want_rem;
      end
      default: begin
      end
    endcase
  end

  // fill count
  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins_en) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.rem_en) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (state_r == S_UPD && done) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // input beat capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_tuser;
      k_r    <= in_tdata[KEY_W-1:0];
      rank_r <= in_tdata[KEY_W+RANK_W-1:KEY_W];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state_r == S_UPD && done) begin
      out_pos_r    <= res_pos;
      out_found_r  <= res_found;
      out_key_r    <= res_key;
      out_status_r <= res_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_key_r, out_found_r, out_pos_r});
  assign out_tuser  = out_status_r;

  // fill count never passes the number of cells
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  // compare flags form a thermometer when the row is sorted
  a_ge_thermo: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UPD |-> ((ge_vec << 1) & ~ge_vec) == '0)
    else $error("row out of order");

  // an equal key is always at or above the lower bound
  a_eq_in_ge: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UPD |-> (eq_vec & ~ge_vec) == '0)
    else $error("equal flag below lower bound");

  // at most one cell answers a rank lookup
  a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UPD |-> $onehot0(hit_vec))
    else $error("several cells match one rank");

  // count changes only in the update cycle
  a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_UPD |=> $stable(count_r))
    else $error("fill count moved outside update");

endmodule

@@ bench/sorted_key_list_tb.sv @@
module sorted_key_list_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import skl_pkg::*;

  localparam int CAPACITY     = CAPACITY_DEF;
  localparam int POS_BITS     = $clog2(CAPACITY + 1);
  localparam int OUT_W        = ((POS_BITS + 33 + 7) / 8) * 8;
  localparam int RANDOM_ITEMS = 1200;
  localparam int HOLD_AFTER   = 250;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_CAP    = 400;
  localparam int PRINT_CAP    = 40;

  // op codes the block does not define, must answer all zeros
  localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;

  localparam key_t KEY_MIN  = 32'h8000_0000;
  localparam key_t KEY_MAX  = 32'h7fff_ffff;
  localparam key_t KEY_NEG1 = 32'hffff_ffff;

  typedef enum int {PH_FILL, PH_MIX, PH_DRAIN} phase_t;

  typedef struct packed {
    logic [POS_BITS-1:0] position;
    logic                found;
    key_t                key_out;
    status_t             status;
  } answer_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    key_t            key;
    rank_t           rank;
    logic            typed;
    answer_t         want;
  } stim_row_t;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [39:0]      in_tdata;   // key [31:0], rank [37:32]
  logic [2:0]       in_tuser;   // op [2:0]
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;  // position [6:0], found [7], key_out [39:8]
  logic [1:0]       out_tuser;  // status [1:0]

  key_t      shadow_keys[$];
  answer_t   answers_due[$];
  stim_row_t directed_rows[$];
  int        errors;
  int        results_seen;

  sorted_key_list dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("[sorted_key_list] ERROR");
    $finish;
  end

  // index of the first stored key not below the given one
  function automatic int slot_for(key_t key);
    int i;
    i = 0;
    while (i < shadow_keys.size() && shadow_keys[i] < key) i++;
    return i;
  endfunction

  // index of the first equal key, -1 if absent
  function automatic int first_equal(key_t key);
    foreach (shadow_keys[i])
      if (shadow_keys[i] == key) return i;
    return -1;
  endfunction

  // apply one op to the shadow list and return the answer it must give
  function automatic answer_t apply_to_shadow(logic [OP_W-1:0] op, key_t key, rank_t rank);
    answer_t a;
    int      slot;
    a = '0;
    case (op)
      OP_INSERT: begin
        slot = slot_for(key);
        a.position = POS_BITS'(slot);
        if (shadow_keys.size() >= CAPACITY) a.status = ST_FULL;
        else shadow_keys.insert(slot, key);
      end
      OP_QUERY: begin
        a.position = POS_BITS'(slot_for(key));
      end
      OP_CONTAINS: begin
        a.found = (first_equal(key) >= 0);
      end
      OP_RANK: begin
        if (rank < shadow_keys.size()) begin
          a.key_out = shadow_keys[rank];
        end else begin
          a.key_out = KEY_NEG1;
          a.status  = ST_RANGE;
        end
      end
      OP_REMOVE: begin
        slot = first_equal(key);
        if (slot >= 0) begin
          a.found = 1'b1;
          shadow_keys.delete(slot);
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  function automatic answer_t answer(int pos, logic hit, key_t kout, status_t st);
    answer_t a;
    a.position = POS_BITS'(pos);
    a.found    = hit;
    a.key_out  = kout;
    a.status   = st;
    return a;
  endfunction

  function automatic stim_row_t row(logic [OP_W-1:0] op, key_t key, rank_t rank,
                                    logic typed, answer_t want);
    stim_row_t r;
    r.op    = op;
    r.key   = key;
    r.rank  = rank;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  // idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // keys: small range for duplicates, extremes, stored ones, full random
  function automatic key_t draw_key(bit prefer_stored);
    int r;
    r = $urandom_range(0, 99);
    if (prefer_stored && shadow_keys.size() > 0 && r < 70)
      return shadow_keys[$urandom_range(0, shadow_keys.size() - 1)];
    r = $urandom_range(0, 99);
    if (r < 35) return key_t'($urandom_range(0, 15)) - key_t'(8);
    if (r < 45) begin
      case ($urandom_range(0, 5))
        0: return KEY_MIN;
        1: return KEY_MIN + key_t'(1);
        2: return KEY_MAX;
        3: return KEY_MAX - key_t'(1);
        4: return KEY_NEG1;
        default: return '0;
      endcase
    end
    if (r < 55 && shadow_keys.size() > 0)
      return shadow_keys[$urandom_range(0, shadow_keys.size() - 1)];
    return key_t'($urandom);
  endfunction

  function automatic rank_t draw_rank();
    if (shadow_keys.size() > 0 && $urandom_range(0, 3) != 0)
      return rank_t'($urandom_range(0, shadow_keys.size() - 1));
    return rank_t'($urandom_range(0, 63));
  endfunction

  // op mix leans to insert while filling and to remove while draining
  function automatic logic [OP_W-1:0] draw_op(phase_t ph);
    int r;
    r = $urandom_range(0, 99);
    case (ph)
      PH_FILL: begin
        if (r < 75) return OP_INSERT;
        if (r < 80) return OP_QUERY;
        if (r < 87) return OP_CONTAINS;
        if (r < 94) return OP_RANK;
        if (r < 98) return OP_REMOVE;
      end
      PH_DRAIN: begin
        if (r < 65) return OP_REMOVE;
        if (r < 70) return OP_INSERT;
        if (r < 78) return OP_QUERY;
        if (r < 88) return OP_CONTAINS;
        if (r < 98) return OP_RANK;
      end
      default: begin
        if (r < 35) return OP_INSERT;
        if (r < 50) return OP_QUERY;
        if (r < 65) return OP_CONTAINS;
        if (r < 80) return OP_RANK;
        if (r < 97) return OP_REMOVE;
      end
    endcase
    return OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (errors < PRINT_CAP)
      $display("result %0d: %s got %0h want %0h", results_seen, what, got, want);
    errors++;
  endtask

  // offer one beat, wait for it to be taken, then, if gap is non-zero, drop valid and idle for that gap
  task automatic offer(stim_row_t r, int gap);
    answer_t predicted;
    in_tuser  <= r.op;
    in_tdata  <= {2'b00, r.rank, r.key};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predicted = apply_to_shadow(r.op, r.key, r.rank);
    answers_due.push_back(r.typed ? r.want : predicted);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 40'({$urandom, $urandom});
      in_tuser  <= OP_W'($urandom);
      repeat (gap) @(negedge clk);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.position = out_tdata[POS_BITS-1:0];
      got.found    = out_tdata[POS_BITS];
      got.key_out  = out_tdata[POS_BITS+32:POS_BITS+1];
      got.status   = status_t'(out_tuser);
      results_seen++;
      if (answers_due.size() == 0) begin
        report_mismatch("beat with nothing pending", 64'(got), '0);
      end else begin
        want = answers_due.pop_front();
        if (got.position !== want.position)
          report_mismatch("position", 64'(got.position), 64'(want.position));
        if (got.found !== want.found)
          report_mismatch("found", 64'(got.found), 64'(want.found));
        if (got.key_out !== want.key_out)
          report_mismatch("key_out", 64'(got.key_out), 64'(want.key_out));
        if (got.status !== want.status)
          report_mismatch("status", 64'(got.status), 64'(want.status));
      end
    end
  end

  // result side: random ready runs and stalls, plus one long hold-off
  initial begin
    int  run;
    bit  level;
    bit  held;
    out_tready = 1'b0;
    run   = 0;
    level = 1'b0;
    held  = 1'b0;
    forever begin
      @(negedge clk);
      if (rst_n && !held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        run = 0;
      end else begin
        if (run == 0) begin
          if ($urandom_range(0, 3) == 0) begin
            level = 1'b0;
            run   = pick_gap();
            if (run == 0) run = 1;
          end else begin
            level = 1'b1;
            run   = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 12);
          end
        end
        out_tready <= level;
        run--;
      end
    end
  end

  // reset, directed table, random phases, drain
  initial begin
    phase_t ph;
    int     sent;
    int     steps;
    int     extra;
    int     mix_len;
    bit     busy;
    bit     over;
    logic [OP_W-1:0] op;

    errors       = 0;
    results_seen = 0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty list, extremes, duplicates, spare ops
    directed_rows.push_back(row(OP_RANK,     '0,       6'd0,  1'b1,
                                answer(0, 1'b0, KEY_NEG1, ST_RANGE)));
    directed_rows.push_back(row(OP_QUERY,    '0,       6'd0,  1'b1,
                                answer(0, 1'b0, '0, ST_OK)));
    directed_rows.push_back(row(OP_CONTAINS, '0,       6'd0,  1'b1,
                                answer(0, 1'b0, '0, ST_OK)));
    directed_rows.push_back(row(OP_REMOVE,   32'sd5,   6'd0,  1'b1,
                                answer(0, 1'b0, '0, ST_OK)));
    directed_rows.push_back(row(OP_INSERT,   KEY_MAX,  6'd63, 1'b1,
                                answer(0, 1'b0, '0, ST_OK)));
    directed_rows.push_back(row(OP_INSERT,   KEY_MIN,  6'd0,  1'b1,
                                answer(0, 1'b0, '0, ST_OK)));
    directed_rows.push_back(row(OP_INSERT,   '0,       6'd0,  1'b1,
                                answer(1, 1'b0, '0, ST_OK)));
    directed_rows.push_back(row(OP_INSERT,   '0,       6'd0,  1'b1,
                                answer(1, 1'b0, '0, ST_OK)));
    directed_rows.push_back(row(OP_QUERY,    KEY_MAX,  6'd0,  1'b1,
                                answer(3, 1'b0, '0, ST_OK)));
    directed_rows.push_back(row(OP_CONTAINS, KEY_MIN,  6'd0,  1'b1,
                                answer(0, 1'b1, '0, ST_OK)));
    directed_rows.push_back(row(OP_RANK,     '0,       6'd0,  1'b1,
                                answer(0, 1'b0, KEY_MIN, ST_OK)));
    directed_rows.push_back(row(OP_RANK,     '0,       6'd3,  1'b1,
                                answer(0, 1'b0, KEY_MAX, ST_OK)));
    directed_rows.push_back(row(OP_RANK,     '0,       6'd4,  1'b1,
                                answer(0, 1'b0, KEY_NEG1, ST_RANGE)));
    directed_rows.push_back(row(OP_RANK,     KEY_NEG1, 6'd63, 1'b1,
                                answer(0, 1'b0, KEY_NEG1, ST_RANGE)));
    directed_rows.push_back(row(OP_REMOVE,   '0,       6'd0,  1'b1,
                                answer(0, 1'b1, '0, ST_OK)));
    directed_rows.push_back(row(OP_SPARE_LO, KEY_NEG1, 6'd63, 1'b1,
                                answer(0, 1'b0, '0, ST_OK)));
    directed_rows.push_back(row(OP_SPARE_MID, KEY_MIN, 6'd0,  1'b1,
                                answer(0, 1'b0, '0, ST_OK)));
    directed_rows.push_back(row(OP_SPARE_HI, KEY_MAX,  6'd1,  1'b1,
                                answer(0, 1'b0, '0, ST_OK)));
    directed_rows.push_back(row(OP_REMOVE,   KEY_MAX,  6'd0,  1'b1,
                                answer(0, 1'b1, '0, ST_OK)));
    directed_rows.push_back(row(OP_INSERT,   KEY_NEG1, 6'd0,  1'b0, '0));
    directed_rows.push_back(row(OP_QUERY,    32'sd1,   6'd0,  1'b0, '0));
    directed_rows.push_back(row(OP_CONTAINS, KEY_NEG1, 6'd0,  1'b0, '0));
    directed_rows.push_back(row(OP_RANK,     '0,       6'd1,  1'b0, '0));
    directed_rows.push_back(row(OP_REMOVE,   KEY_MIN,  6'd0,  1'b0, '0));
    foreach (directed_rows[i]) offer(directed_rows[i], pick_gap());

    // random phases: fill past full, mixed traffic, drain past empty
    sent = 0;
    ph   = PH_FILL;
    while (sent < RANDOM_ITEMS) begin
      busy    = ($urandom_range(0, 2) == 0);
      extra   = $urandom_range(3, 8);
      mix_len = $urandom_range(40, 120);
      steps   = 0;
      do begin
        op = draw_op(ph);
        offer(row(op, draw_key(op != OP_INSERT), draw_rank(), 1'b0, '0),
              busy ? 0 : pick_gap());
        sent++;
        steps++;
        if (ph == PH_FILL && shadow_keys.size() == CAPACITY) extra--;
        if (ph == PH_DRAIN && shadow_keys.size() == 0) extra--;
        over = (steps >= PHASE_CAP) || (sent >= RANDOM_ITEMS) ||
               (ph == PH_MIX ? steps >= mix_len : extra == 0);
      end while (!over);
      case (ph)
        PH_FILL: ph = PH_MIX;
        PH_MIX:  ph = PH_DRAIN;
        default: ph = PH_FILL;
      endcase
    end
    in_tvalid <= 1'b0;

    // wait for every answer, then keep watching for stray beats
    while (answers_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("[sorted_key_list] OK");
    end else begin
      $display("[sorted_key_list] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/skl_pkg.sv
rtl/core/skl_cell.sv
rtl/core/skl_reduce.sv
rtl/core/sorted_key_list.sv
bench/sorted_key_list_tb.sv
